/* src/gsrc_pkg.sv */
// Shared types, codes and the CRC-8 step for the gas sensor readout cache.
// No dependencies; every other file of the block refers to this package.
package gsrc_pkg;

  localparam int unsigned TimeBits   = 32;
  localparam int unsigned FrameBytes = 6;
  localparam int unsigned StoreDepth = FrameBytes - 1;
  localparam int unsigned CountW     = $clog2(FrameBytes);

  localparam logic [15:0] ThresholdReset = 16'd800;
  localparam logic [7:0]  CrcInit        = 8'hFF;
  localparam logic [7:0]  CrcPoly        = 8'h31;

  // Byte positions inside the measurement frame
  localparam logic [CountW-1:0] PosCo2Msb  = CountW'(0);
  localparam logic [CountW-1:0] PosCo2Crc  = CountW'(2);
  localparam logic [CountW-1:0] PosTvocMsb = CountW'(3);
  localparam logic [CountW-1:0] PosLast    = CountW'(StoreDepth);

  typedef enum logic [1:0] {
    OP_QUERY   = 2'd0,
    OP_RX_BYTE = 2'd1,
    OP_BUS_ERR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CACHED  = 3'd0,
    ST_STARTED = 3'd1,
    ST_FRESH   = 3'd2,
    ST_UNCONF  = 3'd3,
    ST_CRCFAIL = 3'd4,
    ST_BUSFAIL = 3'd5
  } status_e;

  typedef enum logic {
    CFG_THRESHOLD  = 1'b0,
    CFG_CONFIGURED = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] co2eq;
    logic [15:0] tvoc;
  } result_t;

  // One byte through the CRC-8 register (MSB first, no reflection)
  function automatic logic [7:0] crc8_byte(logic [7:0] crc_in, logic [7:0] data);
    logic [7:0] crc;
    crc = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if (crc[7]) begin
        crc = {crc[6:0], 1'b0} ^ CrcPoly;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

/* src/gas_sensor_readout_cache.sv */
// Top level of the gas sensor readout cache: query rate limiting, frame
// assembly with CRC-8 checks, cached CO2eq/TVOC values. Uses gsrc_pkg, gsrc_skid.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------
//  input    | in_valid_i / in_stall_o  | operation_i, now_ms_i, rx_byte_i
//  result   | out_valid_o / out_stall_i| status_o, co2eq_o, tvoc_o
//  config   | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item per cycle: each item is decoded against the current state in a
// single pass; its result, if any, is captured at the accepting edge and
// shows on the result port in the next cycle, or waits in the skid stage while
// the result register is held; the input stalls only while that one-entry stage is full.
// Reset is asynchronous, active low: idle, empty caches, threshold 800 ms,
// bus unconfigured. Config writes are always ready; the next item sees them.
module gas_sensor_readout_cache #(
  parameter int unsigned TIME_BITS = gsrc_pkg::TimeBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] now_ms_i,
  input  logic [7:0]  rx_byte_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] co2eq_o,
  output logic [15:0] tvoc_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned CW = gsrc_pkg::CountW;

  // Configuration registers
  logic [15:0] threshold_q;
  logic        configured_q;

  // Block state
  logic [TIME_BITS-1:0] last_update_q, last_update_d;
  logic [15:0]          co2eq_q, co2eq_d;
  logic [15:0]          tvoc_q, tvoc_d;
  logic [CW-1:0]        byte_count_q, byte_count_d;
  logic                 fetch_q, fetch_d;
  logic [7:0]           crc_q, crc_d;
  logic                 crc_ok_q, crc_ok_d;
  logic [7:0]           frame_q [gsrc_pkg::StoreDepth];
  logic                 frame_we;

  // Per-item decode
  logic                 in_accept;
  gsrc_pkg::op_e        op;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] diff;
  logic                 hit;
  logic [7:0]           crc_seed;
  logic                 frame_good;
  logic                 res_valid;
  gsrc_pkg::status_e    res_status;
  gsrc_pkg::result_t    res;
  gsrc_pkg::result_t    out_res;
  logic                 skid_full;

  assign in_accept = in_valid_i && !in_stall_o;
  assign op        = gsrc_pkg::op_e'(operation_i);

  // Elapsed time wraps modulo 2^TIME_BITS
  assign now_t = TIME_BITS'(now_ms_i);
  assign diff  = now_t - last_update_q;
  assign hit   = diff < TIME_BITS'(threshold_q);

  // Each CRC word restarts from the init value at its first byte
  assign crc_seed   = (byte_count_q == gsrc_pkg::PosCo2Msb ||
                       byte_count_q == gsrc_pkg::PosTvocMsb) ? gsrc_pkg::CrcInit : crc_q;
  assign frame_good = crc_ok_q && (crc_q == rx_byte_i);

  always_comb begin
    last_update_d = last_update_q;
    co2eq_d       = co2eq_q;
    tvoc_d        = tvoc_q;
    byte_count_d  = byte_count_q;
    fetch_d       = fetch_q;
    crc_d         = crc_q;
    crc_ok_d      = crc_ok_q;
    frame_we      = 1'b0;
    res_valid     = 1'b0;
    res_status    = gsrc_pkg::ST_CACHED;
    if (in_accept) begin
      unique case (op)
        gsrc_pkg::OP_QUERY: begin
          res_valid = 1'b1;
          if (hit) begin
            res_status = gsrc_pkg::ST_CACHED;
          end else begin
            // record the time; start a fetch or drop the running one
            last_update_d = now_t;
            byte_count_d  = '0;
            fetch_d       = configured_q;
            res_status    = configured_q ? gsrc_pkg::ST_STARTED : gsrc_pkg::ST_UNCONF;
          end
        end
        gsrc_pkg::OP_RX_BYTE: begin
          if (fetch_q) begin
            if (byte_count_q != gsrc_pkg::PosLast) begin
              frame_we     = 1'b1;
              byte_count_d = byte_count_q + CW'(1);
              if (byte_count_q == gsrc_pkg::PosCo2Crc) begin
                crc_ok_d = (crc_q == rx_byte_i);
              end else begin
                crc_d = gsrc_pkg::crc8_byte(crc_seed, rx_byte_i);
              end
            end else begin
              // last byte: check both words, update caches on success
              fetch_d      = 1'b0;
              byte_count_d = '0;
              res_valid    = 1'b1;
              if (frame_good) begin
                co2eq_d    = {frame_q[0], frame_q[1]};
                tvoc_d     = {frame_q[3], frame_q[4]};
                res_status = gsrc_pkg::ST_FRESH;
              end else begin
                res_status = gsrc_pkg::ST_CRCFAIL;
              end
            end
          end
        end
        gsrc_pkg::OP_BUS_ERR: begin
          if (fetch_q) begin
            fetch_d      = 1'b0;
            byte_count_d = '0;
            res_valid    = 1'b1;
            res_status   = gsrc_pkg::ST_BUSFAIL;
          end
        end
        default: begin
          // unused operation code: no result, state held
        end
      endcase
    end
  end

  assign res.status = res_status;
  assign res.co2eq  = co2eq_d;
  assign res.tvoc   = tvoc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q   <= gsrc_pkg::ThresholdReset;
      configured_q  <= 1'b0;
      last_update_q <= '0;
      co2eq_q       <= '0;
      tvoc_q        <= '0;
      byte_count_q  <= '0;
      fetch_q       <= 1'b0;
      crc_q         <= gsrc_pkg::CrcInit;
      crc_ok_q      <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (gsrc_pkg::cfg_idx_e'(cfg_index_i))
          gsrc_pkg::CFG_THRESHOLD:  threshold_q  <= cfg_data_i;
          gsrc_pkg::CFG_CONFIGURED: configured_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      last_update_q <= last_update_d;
      co2eq_q       <= co2eq_d;
      tvoc_q        <= tvoc_d;
      byte_count_q  <= byte_count_d;
      fetch_q       <= fetch_d;
      crc_q         <= crc_d;
      crc_ok_q      <= crc_ok_d;
    end
  end

  // Frame bytes hold no reset; each is written before it is read
  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_q[byte_count_q] <= rx_byte_i;
    end
  end

  gsrc_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_res),
    .full_o      (skid_full)
  );

  assign in_stall_o  = skid_full;
  assign cfg_ready_o = 1'b1;
  assign status_o    = out_res.status;
  assign co2eq_o     = out_res.co2eq;
  assign tvoc_o      = out_res.tvoc;

  // Input only stalls behind a full output register
  a_stall_needs_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result register");

  // Idle means the byte count sits at zero
  a_idle_count_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fetch_q |-> byte_count_q == '0)
    else $error("byte count nonzero while idle");

  // A byte taken during a fetch below the last position advances the count
  a_count_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && op == gsrc_pkg::OP_RX_BYTE && fetch_q &&
     byte_count_q != gsrc_pkg::PosLast) |=> byte_count_q == $past(byte_count_q) + CW'(1))
    else $error("frame byte count did not advance");

  // A fresh result never leaves the fetch running
  a_fresh_ends_fetch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_status == gsrc_pkg::ST_FRESH) |=> !fetch_q)
    else $error("fetch still active after fresh result");

endmodule

/* src/gsrc_skid.sv */
// Result register with a one-entry skid stage for the readout cache.
// Depends on gsrc_pkg for the result item type.
module gsrc_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  gsrc_pkg::result_t res_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output gsrc_pkg::result_t out_o,
  output logic              full_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  gsrc_pkg::result_t out_q, out_d;
  gsrc_pkg::result_t skid_q, skid_d;
  logic              out_pop;

  assign out_pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // input is held off while the skid entry is occupied
      if (out_pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || out_pop) begin
      out_valid_d = res_valid_i;
      if (res_valid_i) begin
        out_d = res_i;
      end
    end else if (res_valid_i) begin
      skid_valid_d = 1'b1;
      skid_d       = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign full_o      = skid_valid_q;

endmodule
